FILE: src/script_lexer_defines.svh
// ----------------------------------------------------------------------------
// script lexer assertion macros
// concurrent assertion helpers, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef SCRIPT_LEXER_DEFINES_SVH
`define SCRIPT_LEXER_DEFINES_SVH
`ifndef SYNTHESIS
`define SLX_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`define SLX_ASSERT_IMP(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`else
`define SLX_ASSERT(label, cond)
`define SLX_ASSERT_IMP(label, pre, post)
`endif
`endif

FILE: src/slx_pkg.sv
// ----------------------------------------------------------------------------
// slx_pkg
// token codes, scan modes and helper functions of the script lexer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package slx_pkg;

    localparam int unsigned TOKEN_LIMIT = 1024;
    localparam logic [15:0] TOKEN_CAP = 16'(TOKEN_LIMIT - 1);

    typedef enum logic [2:0] {
        M_IDLE    = 3'd0,
        M_NUMBER  = 3'd1,
        M_STRING  = 3'd2,
        M_IDENT   = 3'd3,
        M_HOLD    = 3'd4,
        M_COMMENT = 3'd5
    } scan_mode_t;

    localparam logic [5:0] K_NUMBER        = 6'd0;
    localparam logic [5:0] K_STRING        = 6'd1;
    localparam logic [5:0] K_IDENT         = 6'd2;
    localparam logic [5:0] K_VAR           = 6'd3;
    localparam logic [5:0] K_RETURN        = 6'd9;
    localparam logic [5:0] K_EQUAL         = 6'd10;
    localparam logic [5:0] K_NOT_EQUAL     = 6'd11;
    localparam logic [5:0] K_LESS_EQUAL    = 6'd12;
    localparam logic [5:0] K_GREATER_EQUAL = 6'd13;
    localparam logic [5:0] K_AND           = 6'd14;
    localparam logic [5:0] K_OR            = 6'd15;
    localparam logic [5:0] K_ASSIGN        = 6'd16;
    localparam logic [5:0] K_PLUS          = 6'd17;
    localparam logic [5:0] K_MINUS         = 6'd18;
    localparam logic [5:0] K_MULTIPLY      = 6'd19;
    localparam logic [5:0] K_DIVIDE        = 6'd20;
    localparam logic [5:0] K_MODULO        = 6'd21;
    localparam logic [5:0] K_LESS          = 6'd22;
    localparam logic [5:0] K_GREATER       = 6'd23;
    localparam logic [5:0] K_NOT           = 6'd24;
    localparam logic [5:0] K_LPAREN        = 6'd25;
    localparam logic [5:0] K_RPAREN        = 6'd26;
    localparam logic [5:0] K_LBRACE        = 6'd27;
    localparam logic [5:0] K_RBRACE        = 6'd28;
    localparam logic [5:0] K_SEMICOLON     = 6'd29;
    localparam logic [5:0] K_COMMA         = 6'd30;
    localparam logic [5:0] K_DOT           = 6'd31;
    localparam logic [5:0] K_UNKNOWN       = 6'd32;
    localparam logic [5:0] K_EOF           = 6'd33;

    // keyword spellings, zero padded to eight bytes
    typedef logic [7:0] kw_row_t [8];
    localparam kw_row_t KW_TEXT [7] = '{
        '{8'h76, 8'h61, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h66, 8'h75, 8'h6e, 8'h63, 8'h74, 8'h69, 8'h6f, 8'h6e},
        '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h65, 8'h6c, 8'h73, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h66, 8'h6f, 8'h72, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h77, 8'h68, 8'h69, 8'h6c, 8'h65, 8'h00, 8'h00, 8'h00},
        '{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6e, 8'h00, 8'h00}
    };
    localparam logic [3:0] KW_LEN [7] = '{4'd3, 4'd8, 4'd2, 4'd4, 4'd3, 4'd5, 4'd6};

    // one output beat
    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] line;
        logic [15:0] column;
        logic [31:0] int_part;
        logic [29:0] frac;
        logic [3:0]  frac_cnt;
        logic [23:0] text_start;
        logic [15:0] text_len;
        logic        last;
    } token_t;

    function automatic logic [15:0] inc16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic is_numeral(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a))
            || (c == 8'h5f);
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] c);
        logic [5:0] k;
        case (c)
            8'h3d:   k = K_ASSIGN;
            8'h2b:   k = K_PLUS;
            8'h2d:   k = K_MINUS;
            8'h2a:   k = K_MULTIPLY;
            8'h2f:   k = K_DIVIDE;
            8'h25:   k = K_MODULO;
            8'h3c:   k = K_LESS;
            8'h3e:   k = K_GREATER;
            8'h21:   k = K_NOT;
            8'h28:   k = K_LPAREN;
            8'h29:   k = K_RPAREN;
            8'h7b:   k = K_LBRACE;
            8'h7d:   k = K_RBRACE;
            8'h3b:   k = K_SEMICOLON;
            8'h2c:   k = K_COMMA;
            8'h2e:   k = K_DOT;
            default: k = K_UNKNOWN;
        endcase
        return k;
    endfunction

    // lone held operator byte; & and | alone are unknown
    function automatic logic [5:0] held_kind(input logic [7:0] h);
        return ((h == 8'h26) || (h == 8'h7c)) ? K_UNKNOWN : single_kind(h);
    endfunction

    function automatic logic [5:0] pair_kind(input logic [7:0] h, input logic [7:0] c);
        logic [5:0] k;
        k = K_NUMBER;
        if (c == 8'h3d) begin
            case (h)
                8'h3d:   k = K_EQUAL;
                8'h21:   k = K_NOT_EQUAL;
                8'h3c:   k = K_LESS_EQUAL;
                8'h3e:   k = K_GREATER_EQUAL;
                default: k = K_NUMBER;
            endcase
        end
        if ((h == 8'h26) && (c == 8'h26)) k = K_AND;
        if ((h == 8'h7c) && (c == 8'h7c)) k = K_OR;
        return k;
    endfunction

endpackage

FILE: src/script_lexer.sv
// script_lexer: one source byte per beat, tokens out with start line and column.
// output: a token is registered when the byte that completes it is taken.
// throughput: one byte per cycle while out_stall is low; a byte that closes one
// token and makes a second one (or end of text with a pending token) stalls the
// input while the second token leaves through a one-entry spill register.
// reset: asynchronous active low, scanner returns to idle at line 1 column 1.
// ----------------------------------------------------------------------------
// script_lexer
// streaming tokenizer for a small scripting language
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "script_lexer_defines.svh"

module script_lexer
    import slx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_byte,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  token_kind,
    output logic [15:0] start_line,
    output logic [15:0] start_column,
    output logic [31:0] integer_part,
    output logic [29:0] fraction_digits,
    output logic [3:0]  fraction_count,
    output logic [23:0] text_start,
    output logic [15:0] text_length,
    output logic        last
);

    // scanner state
    scan_mode_t  mode_reg, mode_next;
    logic [7:0]  held_reg, held_next;
    logic [15:0] line_reg, line_next, col_reg, col_next;
    logic [15:0] tline_reg, tline_next, tcol_reg, tcol_next;
    logic [31:0] int_reg, int_next;
    logic [29:0] frac_reg, frac_next;
    logic [3:0]  fcnt_reg, fcnt_next;
    logic        point_reg, point_next, squote_reg, squote_next;
    logic [6:0]  kw_reg, kw_next;
    logic [15:0] tlen_reg, tlen_next;
    logic [23:0] tbeg_reg, tbeg_next, pos_reg, pos_next;
    logic [15:0] ntok_reg, ntok_next;

    // output register plus spill register for a second token
    token_t      out_reg, spill_reg;
    logic        ovalid_reg, svalid_reg;

    token_t      tok_a, tok_b;
    logic        emit_a, emit_b;
    logic        accept, out_free;

    // the output stage can take a beat when no spilled beat is pending and it is empty or draining this cycle
    assign out_free = !svalid_reg && (!ovalid_reg || !out_stall);
    assign in_stall = !out_free;
    assign accept   = in_valid && out_free;

    // scan one byte and form up to two tokens from it
    always_comb
    begin
        logic        is_end, tok_ok;
        logic [5:0]  ik, pk;
        logic [35:0] mul;
        logic [35:0] sum;
        logic [7:0]  c;
        logic        go_idle;
        token_t      t;
        c = char_byte;
        is_end = end_of_text || (c == 8'h00);
        mode_next = mode_reg;   held_next = held_reg;
        line_next = line_reg;   col_next = col_reg;
        tline_next = tline_reg; tcol_next = tcol_reg;
        int_next = int_reg;     frac_next = frac_reg; fcnt_next = fcnt_reg;
        point_next = point_reg; squote_next = squote_reg; kw_next = kw_reg;
        tlen_next = tlen_reg;   tbeg_next = tbeg_reg; pos_next = pos_reg + 24'd1;
        ntok_next = ntok_reg;
        emit_a = 1'b0; emit_b = 1'b0;
        tok_a = '0; tok_b = '0;
        go_idle = 1'b0;
        mul = '0; sum = '0; pk = K_NUMBER;

        // keyword resolution for a finished identifier
        ik = K_IDENT;
        for (int k = 6; k >= 0; k--)
        begin
            if (kw_reg[k] && ({12'd0, KW_LEN[k]} == tlen_reg))
            begin
                ik = K_VAR + 6'(k);
            end
        end

        // first token: whatever is pending in the current mode
        t = '0;
        t.line = tline_reg;
        t.column = tcol_reg;
        t.int_part = int_reg;
        t.frac = frac_reg;
        t.frac_cnt = fcnt_reg;
        t.text_start = tbeg_reg;
        t.text_len = tlen_reg;

        if (is_end)
        begin
            case (mode_reg)
                M_NUMBER: begin t.kind = K_NUMBER; emit_a = 1'b1; end
                M_IDENT:  begin t.kind = ik; emit_a = 1'b1; end
                M_STRING: begin t.kind = K_STRING; emit_a = 1'b1; end
                M_HOLD:
                begin
                    t.kind = held_kind(held_reg);
                    emit_a = 1'b1;
                    col_next = inc16(col_reg);
                end
                default: emit_a = 1'b0;
            endcase
        end
        else
        begin
            case (mode_reg)
                M_NUMBER:
                begin
                    if (is_numeral(c))
                    begin
                        if (!point_reg)
                        begin
                            mul = {4'd0, int_reg} * 36'd10;
                            sum = mul + {28'd0, c - 8'h30};
                            int_next = (sum[35:32] != 4'd0) ? 32'hFFFF_FFFF : sum[31:0];
                        end
                        else if (fcnt_reg < 4'd9)
                        begin
                            frac_next = frac_reg * 30'd10 + {22'd0, c - 8'h30};
                            fcnt_next = fcnt_reg + 4'd1;
                        end
                        col_next = inc16(col_reg);
                    end
                    else if ((c == 8'h2e) && !point_reg)
                    begin
                        point_next = 1'b1;
                        col_next = inc16(col_reg);
                    end
                    else
                    begin
                        t.kind = K_NUMBER; emit_a = 1'b1; go_idle = 1'b1;
                    end
                end
                M_IDENT:
                begin
                    if (is_letter(c) || is_numeral(c))
                    begin
                        for (int k = 0; k < 7; k++)
                        begin
                            if ((tlen_reg >= {12'd0, KW_LEN[k]})
                                || (KW_TEXT[k][tlen_reg[2:0]] != c))
                            begin
                                kw_next[k] = 1'b0;
                            end
                        end
                        tlen_next = inc16(tlen_reg);
                        col_next = inc16(col_reg);
                    end
                    else
                    begin
                        t.kind = ik; emit_a = 1'b1; go_idle = 1'b1;
                    end
                end
                M_STRING:
                begin
                    col_next = inc16(col_reg);
                    if (c == (squote_reg ? 8'h27 : 8'h22))
                    begin
                        t.kind = K_STRING; emit_a = 1'b1;
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        tlen_next = inc16(tlen_reg);
                    end
                end
                M_HOLD:
                begin
                    pk = pair_kind(held_reg, c);
                    if (pk != K_NUMBER)
                    begin
                        t.kind = pk; emit_a = 1'b1;
                        col_next = inc16(inc16(col_reg));
                        mode_next = M_IDLE;
                    end
                    else if ((held_reg == 8'h2f) && (c == 8'h2f))
                    begin
                        mode_next = M_COMMENT;
                    end
                    else
                    begin
                        t.kind = held_kind(held_reg); emit_a = 1'b1;
                        col_next = inc16(col_reg);
                        go_idle = 1'b1;
                    end
                end
                M_COMMENT: go_idle = (c == 8'h0a);
                default:   go_idle = 1'b1;
            endcase
        end
        tok_a = t;
        if (tok_a.kind != K_NUMBER)
        begin
            tok_a.int_part = '0; tok_a.frac = '0; tok_a.frac_cnt = '0;
        end
        if ((tok_a.kind < K_STRING) || (tok_a.kind > K_RETURN))
        begin
            tok_a.text_start = '0; tok_a.text_len = '0;
        end
        if (emit_a) ntok_next = inc16(ntok_reg);

        // idle handling of the byte, after a token that it closed
        tok_ok = (ntok_next < TOKEN_CAP);
        if (go_idle)
        begin
            mode_next = M_IDLE;
            if (tok_ok)
            begin
                if ((c == 8'h20) || (c == 8'h09) || (c == 8'h0d))
                begin
                    col_next = inc16(col_next);
                end
                else if (c == 8'h0a)
                begin
                    line_next = inc16(line_reg);
                    col_next = 16'd1;
                end
                else
                begin
                    tline_next = line_reg;
                    tcol_next = col_next;
                    if (is_numeral(c))
                    begin
                        mode_next = M_NUMBER;
                        int_next = {24'd0, c - 8'h30};
                        frac_next = '0; fcnt_next = '0; point_next = 1'b0;
                        col_next = inc16(col_next);
                    end
                    else if ((c == 8'h22) || (c == 8'h27))
                    begin
                        mode_next = M_STRING;
                        squote_next = (c == 8'h27);
                        tbeg_next = pos_reg + 24'd1;
                        tlen_next = '0;
                        col_next = inc16(col_next);
                    end
                    else if (is_letter(c))
                    begin
                        mode_next = M_IDENT;
                        tbeg_next = pos_reg;
                        tlen_next = 16'd1;
                        for (int k = 0; k < 7; k++)
                        begin
                            kw_next[k] = (KW_TEXT[k][0] == c);
                        end
                        col_next = inc16(col_next);
                    end
                    else if ((c == 8'h3d) || (c == 8'h21) || (c == 8'h3c) || (c == 8'h3e)
                        || (c == 8'h26) || (c == 8'h7c) || (c == 8'h2f))
                    begin
                        mode_next = M_HOLD;
                        held_next = c;
                    end
                    else
                    begin
                        emit_b = 1'b1;
                        tok_b.kind = single_kind(c);
                        tok_b.line = line_reg;
                        tok_b.column = col_next;
                        ntok_next = inc16(ntok_next);
                        col_next = inc16(col_next);
                    end
                end
            end
        end

        // end of text: eof token, then back to the reset state
        if (is_end)
        begin
            emit_b = 1'b1;
            tok_b = '0;
            tok_b.kind = K_EOF;
            tok_b.line = line_reg;
            tok_b.column = col_next;
            tok_b.last = 1'b1;
            mode_next = M_IDLE; held_next = '0;
            line_next = 16'd1; col_next = 16'd1; tline_next = 16'd1; tcol_next = 16'd1;
            int_next = '0; frac_next = '0; fcnt_next = '0; point_next = 1'b0;
            squote_next = 1'b0; kw_next = 7'h7F; tlen_next = '0; tbeg_next = '0;
            pos_next = '0; ntok_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE; held_reg <= '0;
            line_reg <= 16'd1; col_reg <= 16'd1; tline_reg <= 16'd1; tcol_reg <= 16'd1;
            int_reg <= '0; frac_reg <= '0; fcnt_reg <= '0; point_reg <= 1'b0;
            squote_reg <= 1'b0; kw_reg <= 7'h7F; tlen_reg <= '0; tbeg_reg <= '0;
            pos_reg <= '0; ntok_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next; held_reg <= held_next;
            line_reg <= line_next; col_reg <= col_next;
            tline_reg <= tline_next; tcol_reg <= tcol_next;
            int_reg <= int_next; frac_reg <= frac_next; fcnt_reg <= fcnt_next;
            point_reg <= point_next; squote_reg <= squote_next; kw_reg <= kw_next;
            tlen_reg <= tlen_next; tbeg_reg <= tbeg_next;
            pos_reg <= pos_next; ntok_reg <= ntok_next;
        end
    end

    // output and spill: the spill beat follows the output beat in order
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
            svalid_reg <= 1'b0;
        end
        else
        begin
            if (svalid_reg)
            begin
                if (!out_stall)
                begin
                    ovalid_reg <= 1'b1;
                    svalid_reg <= 1'b0;
                end
            end
            else if (accept)
            begin
                ovalid_reg <= emit_a || emit_b;
                svalid_reg <= emit_a && emit_b;
            end
            else if (!out_stall)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (svalid_reg)
        begin
            if (!out_stall) out_reg <= spill_reg;
        end
        else if (accept)
        begin
            out_reg <= emit_a ? tok_a : tok_b;
            spill_reg <= tok_b;
        end
    end

    assign out_valid       = ovalid_reg;
    assign token_kind      = out_reg.kind;
    assign start_line      = out_reg.line;
    assign start_column    = out_reg.column;
    assign integer_part    = out_reg.int_part;
    assign fraction_digits = out_reg.frac;
    assign fraction_count  = out_reg.frac_cnt;
    assign text_start      = out_reg.text_start;
    assign text_length     = out_reg.text_len;
    assign last            = out_reg.last;

    // a spilled beat always sits behind a valid output beat
    `SLX_ASSERT(a_spill_behind_out, !svalid_reg || ovalid_reg)
    // no byte is taken while a spilled beat is pending
    `SLX_ASSERT_IMP(a_no_accept_spill, svalid_reg, !accept)
    // fraction digit count never passes nine
    `SLX_ASSERT(a_frac_count, fcnt_reg <= 4'd9)

endmodule
